FILE: hw/rtl/rgbup_pkg.sv
// Shared types and constants for the RGB565 four-to-five upscaler.
package rgbup_pkg;

  localparam int ROW_BITS  = 10;
  localparam int WIDE_BITS = (ROW_BITS > 10) ? ROW_BITS : 10;
  localparam int LANES     = 4;

  localparam logic [31:0] PIX_MASK2 = 32'hF7DE_F7DE;
  localparam logic [11:0] ERR_MAX   = 12'd2047;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    REG_ROW_STEP        = 3'd0,
    REG_ROW_MODULUS     = 3'd1,
    REG_BLEND_THRESHOLD = 3'd2,
    REG_OUT_ROWS        = 3'd3,
    REG_BLOCKS_PER_ROW  = 3'd4,
    REG_TOP_SKIP_ROWS   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [9:0] row_step;
    logic [9:0] row_modulus;
    logic [9:0] blend_threshold;
    logic [9:0] out_rows;
    logic [7:0] blocks_per_row;
    logic [7:0] top_skip_rows;
  } cfg_t;

  typedef struct packed {
    logic [9:0] next_src_row;
    logic       next_needs_below;
    logic       row_done;
    logic       frame_done;
  } row_status_t;

endpackage

FILE: hw/rtl/rgbup_lane.sv
// One pixel-pair lane: channel mask and optional vertical average.
module rgbup_lane
  import rgbup_pkg::*;
(
  input  word_t cur,
  input  word_t below,
  input  logic  blend,
  output word_t word
);

  word_t cur_m;
  word_t sum;

  assign cur_m = cur & PIX_MASK2;
  // halves are masked first, so per-channel sums cannot carry across channels
  assign sum   = (cur_m >> 1) + ((below & PIX_MASK2) >> 1);
  assign word  = blend ? (sum & PIX_MASK2) : cur_m;

endmodule

FILE: hw/rtl/rgbup_merge.sv
// Merge stage: spreads four lane words into five output words.
module rgbup_merge
  import rgbup_pkg::*;
(
  input  word_t lane_w [LANES],
  output word_t w0,
  output word_t w1,
  output word_t w2,
  output word_t w3,
  output word_t w4
);

  word_t ab, cd, ef, gh;

  assign ab = lane_w[0];
  assign cd = lane_w[1];
  assign ef = lane_w[2];
  assign gh = lane_w[3];

  assign w0 = ab;
  // low half: b/2 + c/2, high half: c
  assign w1 = (ab >> 17) + ((cd & 32'h0000_FFFF) >> 1) + (cd << 16);
  assign w2 = (cd >> 16) + (ef << 16);
  // low half: f, high half: f/2 + g/2
  assign w3 = (ef >> 16) + ((ef & 32'hFFFF_0000) >> 1) + ((gh & 32'h0000_FFFF) << 15);
  assign w4 = gh;

endmodule

FILE: hw/rtl/rgbup_rowctl.sv
// Column/row counters and Bresenham row error accumulator.
module rgbup_rowctl
  import rgbup_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  logic        sof,
  input  cfg_t        cfg,
  output logic        blend,
  output row_status_t status
);

  logic [7:0]          col_r, col_nxt;
  logic [9:0]          row_r, row_nxt;
  logic [10:0]         err_r, err_nxt;
  logic [ROW_BITS-1:0] src_r, src_nxt;

  logic [7:0]          col0;
  logic [9:0]          row0;
  logic [10:0]         err0;
  logic [ROW_BITS-1:0] src0;
  logic [8:0]          col_inc;
  logic [10:0]         row_inc;
  logic [11:0]         err_add;
  logic [11:0]         err_sub;
  logic                row_end;
  logic                frame_end;
  logic [ROW_BITS-1:0] rep_row;
  logic [WIDE_BITS-1:0] rep_wide;

  assign col0 = sof ? '0 : col_r;
  assign row0 = sof ? '0 : row_r;
  assign err0 = sof ? '0 : err_r;
  assign src0 = sof ? '0 : src_r;

  assign blend = err0 >= {1'b0, cfg.blend_threshold};

  always_comb begin
    col_inc = {1'b0, col0} + 9'd1;
    row_inc = {1'b0, row0} + 11'd1;
    err_add = {1'b0, err0} + {2'b00, cfg.row_step};
    err_sub = err_add;
    col_nxt = col_inc[7:0];
    row_nxt = row0;
    err_nxt = err0;
    src_nxt = src0;
    row_end   = 1'b0;
    frame_end = 1'b0;
    if (col_inc >= {1'b0, cfg.blocks_per_row}) begin
      col_nxt = '0;
      row_end = 1'b1;
      if (err_add >= {2'b00, cfg.row_modulus}) begin
        err_sub = err_add - {2'b00, cfg.row_modulus};
        src_nxt = src0 + ROW_BITS'(1);
      end
      err_nxt = (err_sub > ERR_MAX) ? ERR_MAX[10:0] : err_sub[10:0];
      row_nxt = row_inc[9:0];
      if (row_inc >= {1'b0, cfg.out_rows}) begin
        frame_end = 1'b1;
        row_nxt = '0;
        err_nxt = '0;
        src_nxt = '0;
      end
    end
  end

  assign rep_row  = src_nxt + ROW_BITS'(cfg.top_skip_rows);
  assign rep_wide = WIDE_BITS'(rep_row);
  // next_src_row, next_needs_below, row_done, frame_done
  assign status   = {rep_wide[9:0], err_nxt >= {1'b0, cfg.blend_threshold}, row_end, frame_end};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      err_r <= '0;
      src_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      err_r <= err_nxt;
      src_r <= src_nxt;
    end
  end

endmodule

FILE: hw/rtl/rgb565_upscale_four_to_five_unit.sv
// Top level of the RGB565 four-to-five upscaler with vertical blending.
//
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | start_of_frame, 4 current words, 4 words below
// out     | output    | out_valid / out_ready| 5 pixel words, next source row, status flags
// cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
// One block per cycle unless out_ready stalls; accept loads the output register.
// Latency is set by the single output register behind the four lanes and merge.
// A full output register still takes a new block when out_ready is high.
// Sync active-low reset clears counters, accumulator and out valid; loads cfg defaults.
module rgb565_upscale_four_to_five_unit
  import rgbup_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_of_frame,
  input  logic [31:0] in_cur_w0,
  input  logic [31:0] in_cur_w1,
  input  logic [31:0] in_cur_w2,
  input  logic [31:0] in_cur_w3,
  input  logic [31:0] in_below_w0,
  input  logic [31:0] in_below_w1,
  input  logic [31:0] in_below_w2,
  input  logic [31:0] in_below_w3,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_w0,
  output logic [31:0] out_w1,
  output logic [31:0] out_w2,
  output logic [31:0] out_w3,
  output logic [31:0] out_w4,
  output logic [9:0]  out_next_src_row,
  output logic        out_next_needs_below,
  output logic        out_row_done,
  output logic        out_frame_done
);

  cfg_t        cfg_r;
  logic        accept;
  logic        blend;
  row_status_t status;
  word_t       cur_w  [LANES];
  word_t       below_w[LANES];
  word_t       lane_w [LANES];
  word_t       m0, m1, m2, m3, m4;

  logic        out_valid_r;
  word_t       w0_r, w1_r, w2_r, w3_r, w4_r;
  row_status_t status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_step        <= 10'd232;
      cfg_r.row_modulus     <= 10'd240;
      cfg_r.blend_threshold <= 10'd180;
      cfg_r.out_rows        <= 10'd240;
      cfg_r.blocks_per_row  <= 8'd40;
      cfg_r.top_skip_rows   <= 8'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_STEP:        cfg_r.row_step        <= cfg_wdata;
        REG_ROW_MODULUS:     cfg_r.row_modulus     <= cfg_wdata;
        REG_BLEND_THRESHOLD: cfg_r.blend_threshold <= cfg_wdata;
        REG_OUT_ROWS:        cfg_r.out_rows        <= cfg_wdata;
        REG_BLOCKS_PER_ROW:  cfg_r.blocks_per_row  <= cfg_wdata[7:0];
        REG_TOP_SKIP_ROWS:   cfg_r.top_skip_rows   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign cur_w[0]   = in_cur_w0;
  assign cur_w[1]   = in_cur_w1;
  assign cur_w[2]   = in_cur_w2;
  assign cur_w[3]   = in_cur_w3;
  assign below_w[0] = in_below_w0;
  assign below_w[1] = in_below_w1;
  assign below_w[2] = in_below_w2;
  assign below_w[3] = in_below_w3;

  rgbup_rowctl u_rowctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .sof     (in_start_of_frame),
    .cfg     (cfg_r),
    .blend   (blend),
    .status  (status)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    rgbup_lane u_lane (
      .cur   (cur_w[i]),
      .below (below_w[i]),
      .blend (blend),
      .word  (lane_w[i])
    );
  end

  rgbup_merge u_merge (
    .lane_w (lane_w),
    .w0     (m0),
    .w1     (m1),
    .w2     (m2),
    .w3     (m3),
    .w4     (m4)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w0_r     <= m0;
      w1_r     <= m1;
      w2_r     <= m2;
      w3_r     <= m3;
      w4_r     <= m4;
      status_r <= status;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_w0               = w0_r;
  assign out_w1               = w1_r;
  assign out_w2               = w2_r;
  assign out_w3               = w3_r;
  assign out_w4               = w4_r;
  assign out_next_src_row     = status_r.next_src_row;
  assign out_next_needs_below = status_r.next_needs_below;
  assign out_row_done         = status_r.row_done;
  assign out_frame_done       = status_r.frame_done;

  a_frame_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_done || out_row_done))
    else $error("frame_done without row_done");

  a_accept_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted transaction did not reach output register");

  // after a frame ends the source row restarts at the skip offset
  a_frame_restart_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_next_src_row == {2'b00, cfg_r.top_skip_rows}))
    else $error("source row not restarted at end of frame");

endmodule
